/* hw/rtl/bcpe_pkg.sv */
// Package for the Bezier curve point evaluator.
// Holds payload structs, command codes and fixed field widths.
// No dependencies.
package bcpe_pkg;

  localparam int COORD_W = 32;
  localparam int T_FRAC  = 16;
  localparam int T_W     = T_FRAC + 1;
  localparam int IDX_W   = 4;
  localparam int DEG_W   = 4;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [DEG_W-1:0] DEG_RESET = 4'd3;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] point_x_in;
    logic signed [COORD_W-1:0] point_y_in;
    logic [T_W-1:0]            t_param;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x_out;
    logic signed [COORD_W-1:0] point_y_out;
    logic                      status;
  } out_item_t;

endpackage

/* hw/rtl/bezier_curve_point_eval.sv */
// Bezier curve point evaluator: sequencer, control point and scratch memories,
// two interpolation lanes. Uses bcpe_pkg, bcpe_ram, bcpe_lerp.
//
// Usage:
//   in_valid/in_ready/in_payload carry one command transaction: store a control
//   point, evaluate the curve at t, or read a stored point. Each transaction
//   gives exactly one result on out_valid/out_ready/out_payload.
//   cfg_we/cfg_wdata set the curve degree (reset value 3); write only while idle.
// Timing:
//   One transaction at a time. Store and error results go straight to the done
//   state; reads and evaluations at t = 0, t >= 1 or degree 0 read the control
//   memory once first. An interior evaluation walks the control memory, then the
//   scratch memory, through one read port each: round r takes (deg - r + 2)
//   reads, then the lerp pipeline drains. These single read ports set its length.
// Reset:
//   rst_n is synchronous, active low; clears control state and sets the degree to 3.
//   Memory contents are undefined until written.
// Stall:
//   A finished result waits in the output register; a new transaction is taken
//   meanwhile and its result is held back until the output is free.
module bezier_curve_point_eval #(
  parameter int MAX_POINTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bcpe_pkg::in_item_t                in_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bcpe_pkg::out_item_t               out_payload,
  input  logic                              cfg_we,
  input  logic [bcpe_pkg::DEG_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = bcpe_pkg::COORD_W;
  localparam int IW = bcpe_pkg::IDX_W;
  localparam int DW = bcpe_pkg::DEG_W;
  localparam int TF = bcpe_pkg::T_FRAC;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RDCTL = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DW-1:0]         deg_cfg_r;
  logic [DW-1:0]         deg;
  logic [DW-1:0]         round_r, round_nxt;
  logic [DW-1:0]         k_r, k_nxt;
  logic [TF-1:0]         t_r;
  logic                  v1_r, v1_nxt;
  logic [DW-1:0]         k1_r;
  logic                  v2_r, v2_nxt;
  logic [DW-1:0]         wk2_r;
  logic signed [CW-1:0]  prev_x_r, prev_y_r;
  logic signed [CW-1:0]  res_x_r, res_y_r;
  logic                  res_st_r;
  logic                  out_valid_r, out_valid_nxt;
  bcpe_pkg::out_item_t   out_r;

  logic                  accept;
  logic                  out_load;
  logic                  idx_ok;
  logic [IW+AW-1:0]      idx_wide, deg_wide, k_wide, wk2_wide;
  logic [AW-1:0]         ctrl_raddr, work_raddr;
  logic [2*CW-1:0]       ctrl_rdata, work_rdata, rd_data;
  logic signed [CW-1:0]  rd_x, rd_y, lerp_x, lerp_y;
  logic                  ctrl_we;
  logic                  lerp_en;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign deg = (int'(deg_cfg_r) > MAX_POINTS - 1) ? DW'(MAX_POINTS - 1) : deg_cfg_r;
  assign idx_ok = int'(in_payload.point_index) < MAX_POINTS;

  assign idx_wide = {{AW{1'b0}}, in_payload.point_index};
  assign deg_wide = {{AW{1'b0}}, deg};
  assign k_wide   = {{AW{1'b0}}, k_r};
  assign wk2_wide = {{AW{1'b0}}, wk2_r};

  // read address for the control memory: command index, end point, or round one walk
  always_comb begin
    ctrl_raddr = k_wide[AW-1:0];
    if (state_r == ST_IDLE) begin
      if (in_payload.command == bcpe_pkg::CMD_READ) begin
        ctrl_raddr = idx_wide[AW-1:0];
      end else if (in_payload.t_param == '0) begin
        ctrl_raddr = '0;
      end else begin
        ctrl_raddr = deg_wide[AW-1:0];
      end
    end
  end
  assign work_raddr = k_wide[AW-1:0];

  assign ctrl_we = accept && (in_payload.command == bcpe_pkg::CMD_STORE) && idx_ok;

  bcpe_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_ctrl_ram (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr (idx_wide[AW-1:0]),
    .wdata ({in_payload.point_x_in, in_payload.point_y_in}),
    .raddr (ctrl_raddr),
    .rdata (ctrl_rdata)
  );

  bcpe_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_work_ram (
    .clk   (clk),
    .we    (v2_r),
    .waddr (wk2_wide[AW-1:0]),
    .wdata ({lerp_x, lerp_y}),
    .raddr (work_raddr),
    .rdata (work_rdata)
  );

  // first round reads control points, later rounds the scratch memory
  assign rd_data = (round_r == DW'(1)) ? ctrl_rdata : work_rdata;
  assign rd_x    = rd_data[2*CW-1:CW];
  assign rd_y    = rd_data[CW-1:0];
  assign lerp_en = v1_r && (k1_r != '0);

  bcpe_lerp u_lerp_x (
    .clk (clk), .en (lerp_en), .a (prev_x_r), .b (rd_x), .t (t_r), .q (lerp_x)
  );

  bcpe_lerp u_lerp_y (
    .clk (clk), .en (lerp_en), .a (prev_y_r), .b (rd_y), .t (t_r), .q (lerp_y)
  );

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    k_nxt     = k_r;
    v1_nxt    = 1'b0;
    v2_nxt    = lerp_en;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          if (in_payload.command == bcpe_pkg::CMD_READ) begin
            if (idx_ok && in_payload.point_index <= deg) begin
              state_nxt = ST_RDCTL;
            end
          end else if (in_payload.command == bcpe_pkg::CMD_EVAL) begin
            if (in_payload.t_param == '0 || in_payload.t_param[TF] || deg == '0) begin
              state_nxt = ST_RDCTL;
            end else begin
              state_nxt = ST_ROUND;
              round_nxt = DW'(1);
              k_nxt     = '0;
            end
          end
        end
      end
      ST_RDCTL: state_nxt = ST_DONE;
      ST_ROUND: begin
        v1_nxt = 1'b1;
        if (k_r == deg - round_r + DW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + DW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for all writes of this round before the next one reads
        if (!v1_r && !v2_r) begin
          if (round_r == deg) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ROUND;
            round_nxt = round_r + DW'(1);
            k_nxt     = '0;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      deg_cfg_r   <= bcpe_pkg::DEG_RESET;
      round_r     <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      k_r         <= k_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        deg_cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k1_r <= k_r;
    if (v1_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    wk2_r <= k1_r - DW'(1);
    if (accept) begin
      t_r      <= in_payload.t_param[TF-1:0];
      res_x_r  <= '0;
      res_y_r  <= '0;
      case (in_payload.command)
        bcpe_pkg::CMD_STORE: res_st_r <= !idx_ok;
        bcpe_pkg::CMD_EVAL:  res_st_r <= 1'b0;
        bcpe_pkg::CMD_READ:  res_st_r <= !(idx_ok && in_payload.point_index <= deg);
        default:             res_st_r <= 1'b1;
      endcase
    end else if (state_r == ST_RDCTL) begin
      res_x_r <= ctrl_rdata[2*CW-1:CW];
      res_y_r <= ctrl_rdata[CW-1:0];
    end else if (v2_r) begin
      // last write of the last round lands in entry zero: the curve point
      res_x_r <= lerp_x;
      res_y_r <= lerp_y;
    end
    if (out_load) begin
      out_r.point_x_out <= res_x_r;
      out_r.point_y_out <= res_y_r;
      out_r.status      <= res_st_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

/* hw/rtl/bcpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bcpe_lerp.sv */
// One coordinate lane of the interpolation: a + floor((b - a) * t / 2^T_FRAC),
// saturated. Registered product, add and saturate after. Uses bcpe_pkg.
module bcpe_lerp (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bcpe_pkg::COORD_W-1:0] a,
  input  logic signed [bcpe_pkg::COORD_W-1:0] b,
  input  logic [bcpe_pkg::T_FRAC-1:0]         t,
  output logic signed [bcpe_pkg::COORD_W-1:0] q
);

  localparam int CW = bcpe_pkg::COORD_W;
  localparam int TF = bcpe_pkg::T_FRAC;
  localparam int PW = CW + 1 + TF + 1;
  localparam int SW = CW + 3;

  localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = -SW'({1'b1, {(CW-1){1'b0}}});

  logic signed [CW:0]   diff;
  logic signed [PW-1:0] prod_r;
  logic signed [CW-1:0] a_r;
  logic signed [SW-1:0] sum;

  assign diff = {b[CW-1], b} - {a[CW-1], a};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(diff * $signed({1'b0, t}));
      a_r    <= a;
    end
  end

  // arithmetic shift gives floor for negative differences
  assign sum = SW'(a_r) + SW'(prod_r >>> TF);

  always_comb begin
    if (sum > MAXV) begin
      q = MAXV[CW-1:0];
    end else if (sum < MINV) begin
      q = MINV[CW-1:0];
    end else begin
      q = sum[CW-1:0];
    end
  end

endmodule
